// ----- src/ttt_pkg.sv -----
// Package: constants, types and helper functions of the three-way transposition table.
package ttt_pkg;

    localparam int MAX_INDEX_BITS = 16;
    localparam int WAYS           = 3;
    localparam int SLOT_W         = 64 + 64 + 8;
    localparam int ROW_W          = WAYS * SLOT_W;

    typedef logic [MAX_INDEX_BITS-1:0] row_addr_t;

    typedef enum logic [2:0] {
        OP_PROBE   = 3'd0,
        OP_STORE   = 3'd1,
        OP_EVAL    = 3'd2,
        OP_ADVANCE = 3'd3,
        OP_CLEAR   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        REG_INDEX_BITS = 2'd0,
        REG_KEEP_MOVE  = 2'd1,
        REG_GUARD      = 2'd2,
        REG_EXACT      = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_EXEC  = 2'd2,
        ST_CLEAR = 2'd3
    } state_t;

    typedef struct packed {
        logic [63:0] data;
        logic [63:0] check;
        logic [7:0]  stamp;
    } slot_t;

    // Depth field of a packed data word.
    function automatic logic signed [7:0] depth_of(input logic [63:0] d);
        depth_of = d[39:32];
    endfunction

    function automatic logic [63:0] pack(
        input logic [7:0]  dep,
        input logic [15:0] sc,
        input logic [1:0]  bnd,
        input logic [15:0] mv,
        input logic        pv,
        input logic [15:0] ev
    );
        pack = {5'd0, ev, pv, bnd, dep, sc, mv};
    endfunction

endpackage

// ----- src/ttt_ram.sv -----
// Single-port bucket memory; read data is registered and appears in the cycle after the address.
module ttt_ram #(
    parameter int AW = 16,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- src/three_way_transposition_table.sv -----
// Top level: three-way set-associative transposition table with a bucket memory.
//
//  Channel  Signals                                   Direction  Transfer
//  command  start, busy, operation, key, depth, ...   in         start && !busy
//  result   done, hit, depth_out, ..., eval_out       out        done (one cycle)
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data in         cfg_valid && cfg_ready
//
// Probe, store and eval-only store go through accept, bucket read, decide and write
// back through the single memory port. Advance bumps the generation in the read state.
// Clear sweeps one bucket a cycle over all 2**16 buckets, and the same clearing
// pass runs after reset before the first command is taken.
// The receiver cannot stall; done marks each result for one cycle.
module three_way_transposition_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         operation,
    input  logic [63:0]        key,
    input  logic signed [7:0]  depth,
    input  logic signed [15:0] score,
    input  logic [1:0]         bound,
    input  logic [15:0]        best_move,
    input  logic               is_pv,
    input  logic signed [15:0] static_eval,
    output logic               done,
    output logic               hit,
    output logic signed [7:0]  depth_out,
    output logic signed [15:0] score_out,
    output logic [1:0]         bound_out,
    output logic [15:0]        move_out,
    output logic               pv_out,
    output logic signed [15:0] eval_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int AW = ttt_pkg::MAX_INDEX_BITS;
    localparam int SW = ttt_pkg::SLOT_W;
    localparam int W  = ttt_pkg::WAYS;

    ttt_pkg::state_t state_reg, state_next;
    logic [2:0]  op_reg;
    logic [63:0] key_reg;
    logic [7:0]  depth_reg;
    logic [15:0] score_reg, move_reg, eval_reg;
    logic [1:0]  bound_reg;
    logic        pv_reg;
    logic [7:0]  gen_reg, gen_next;
    logic [4:0]  ibits_reg;
    logic        keep_reg, guard_reg;
    logic [1:0]  exact_reg;
    ttt_pkg::row_addr_t clr_reg, clr_next;
    logic        cmd_clear_reg;

    logic        done_next, hit_next;
    logic [63:0] out_data_next, out_data_reg;
    logic        done_reg, hit_reg;

    logic                      ram_we;
    ttt_pkg::row_addr_t        ram_addr, row_addr;
    logic [ttt_pkg::ROW_W-1:0] ram_wdata, ram_rdata;

    ttt_pkg::slot_t slots [W];
    ttt_pkg::slot_t new_slots [W];

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != ttt_pkg::ST_IDLE);

    // Bucket index: low key bits, saturated width, zero width gives bucket zero.
    always_comb
    begin
        logic [4:0] bits;
        logic [AW-1:0] mask;
        bits = (ibits_reg > 5'(AW)) ? 5'(AW) : ibits_reg;
        mask = AW'(({{AW{1'b0}}, 1'b1} << bits) - 1'b1);
        row_addr = key_reg[AW-1:0] & mask;
    end

    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            slots[i] = ram_rdata[i*SW +: SW];
        end
    end

    ttt_ram #(.AW(AW), .DW(ttt_pkg::ROW_W)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttt_pkg::ST_CLEAR;
            gen_reg   <= '0;
            clr_reg   <= '0;
            ibits_reg <= 5'd16;
            keep_reg  <= 1'b1;
            guard_reg <= 1'b1;
            exact_reg <= 2'd3;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gen_reg   <= gen_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            hit_reg   <= hit_next;
            if (cfg_valid && cfg_ready)
            begin
                case (ttt_pkg::reg_idx_t'(cfg_index))
                    ttt_pkg::REG_INDEX_BITS: ibits_reg <= cfg_data[4:0];
                    ttt_pkg::REG_KEEP_MOVE:  keep_reg  <= cfg_data[0];
                    ttt_pkg::REG_GUARD:      guard_reg <= cfg_data[0];
                    ttt_pkg::REG_EXACT:      exact_reg <= cfg_data[1:0];
                    default:                 keep_reg  <= keep_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (start && !busy)
        begin
            op_reg    <= operation;
            key_reg   <= key;
            depth_reg <= depth;
            score_reg <= score;
            bound_reg <= bound;
            move_reg  <= best_move;
            pv_reg    <= is_pv;
            eval_reg  <= static_eval;
        end
    end

    assign done      = done_reg;
    assign hit       = hit_reg;
    assign move_out  = out_data_reg[15:0];
    assign score_out = out_data_reg[31:16];
    assign depth_out = out_data_reg[39:32];
    assign bound_out = out_data_reg[41:40];
    assign pv_out    = out_data_reg[42];
    assign eval_out  = out_data_reg[58:43];

    always_comb
    begin
        logic [W-1:0]      match;
        logic [7:0]        age [W];
        logic signed [10:0] val [W];
        logic signed [10:0] worst;
        int                victim, target;
        logic              found, same, drop, exact;
        logic [63:0]       old, wd;
        logic [15:0]       mv;
        logic signed [9:0] lhs, rhs;

        state_next    = state_reg;
        gen_next      = gen_reg;
        clr_next      = clr_reg;
        done_next     = 1'b0;
        hit_next      = 1'b0;
        out_data_next = '0;
        ram_we        = 1'b0;
        ram_addr      = row_addr;
        ram_wdata     = ram_rdata;
        match = '0;
        worst = '0;
        victim = 0;
        target = -1;
        found = 1'b0;
        same = 1'b0;
        drop = 1'b0;
        exact = 1'b0;
        old = '0;
        wd = '0;
        mv = '0;
        lhs = '0;
        rhs = '0;
        for (int i = 0; i < W; i++)
        begin
            new_slots[i] = slots[i];
            match[i] = ((slots[i].check ^ slots[i].data) == key_reg);
            age[i]   = gen_reg - slots[i].stamp;
            val[i]   = 11'(ttt_pkg::depth_of(slots[i].data)) - 11'(3 * age[i]);
        end

        case (state_reg)
            ttt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ttt_pkg::ST_READ;
                end
            end
            ttt_pkg::ST_READ:
            begin
                // The bucket read is issued here; data returns next cycle.
                case (op_reg)
                    ttt_pkg::OP_PROBE, ttt_pkg::OP_STORE, ttt_pkg::OP_EVAL:
                        state_next = ttt_pkg::ST_EXEC;
                    ttt_pkg::OP_ADVANCE:
                    begin
                        gen_next   = gen_reg + 8'd1;
                        done_next  = 1'b1;
                        state_next = ttt_pkg::ST_IDLE;
                    end
                    ttt_pkg::OP_CLEAR:
                    begin
                        gen_next   = '0;
                        clr_next   = '0;
                        state_next = ttt_pkg::ST_CLEAR;
                    end
                    default:
                    begin
                        done_next  = 1'b1;
                        state_next = ttt_pkg::ST_IDLE;
                    end
                endcase
            end
            ttt_pkg::ST_EXEC:
            begin
                done_next  = 1'b1;
                state_next = ttt_pkg::ST_IDLE;
                case (op_reg)
                    ttt_pkg::OP_PROBE:
                    begin
                        for (int i = W - 1; i >= 0; i--)
                        begin
                            if (match[i])
                            begin
                                target = i;
                            end
                        end
                        if (target >= 0)
                        begin
                            hit_next = 1'b1;
                            out_data_next = slots[target].data;
                            new_slots[target].stamp = gen_reg;
                            ram_we = 1'b1;
                        end
                    end
                    ttt_pkg::OP_STORE:
                    begin
                        worst = 11'sd1023;
                        for (int i = 0; i < W; i++)
                        begin
                            if (!found)
                            begin
                                if (match[i])
                                begin
                                    victim = i;
                                    found  = 1'b1;
                                end
                                else if (i == 0 || val[i] < worst)
                                begin
                                    worst  = val[i];
                                    victim = i;
                                end
                            end
                        end
                        old  = slots[victim].data;
                        same = (old != '0) && match[victim];
                        mv   = move_reg;
                        if (keep_reg && same && (move_reg == '0))
                        begin
                            mv = old[15:0];
                        end
                        exact = (bound_reg == exact_reg);
                        lhs = 10'($signed(depth_reg)) + 10'(2 * pv_reg);
                        rhs = 10'(ttt_pkg::depth_of(old)) - 10'sd4;
                        drop = guard_reg && same &&
                               !(exact || (lhs > rhs) || (age[victim] != 8'd0));
                        wd = ttt_pkg::pack(depth_reg, score_reg, bound_reg, mv, pv_reg,
                                           eval_reg);
                        if (!drop)
                        begin
                            new_slots[victim].data  = wd;
                            new_slots[victim].check = key_reg ^ wd;
                            new_slots[victim].stamp = gen_reg;
                            ram_we = 1'b1;
                        end
                    end
                    ttt_pkg::OP_EVAL:
                    begin
                        for (int i = 0; i < W; i++)
                        begin
                            if (!found)
                            begin
                                if (match[i])
                                begin
                                    target = i;
                                    found  = 1'b1;
                                end
                                else if (target < 0 && ((slots[i].data == '0) ||
                                         (ttt_pkg::depth_of(slots[i].data) < -8'sd7) ||
                                         (age[i] > 8'd2)))
                                begin
                                    target = i;
                                end
                            end
                        end
                        if (target >= 0)
                        begin
                            mv = match[target] ? slots[target].data[15:0] : 16'd0;
                            wd = ttt_pkg::pack(8'hF8, 16'd0, 2'd0, mv, 1'b0, eval_reg);
                            new_slots[target].data  = wd;
                            new_slots[target].check = key_reg ^ wd;
                            new_slots[target].stamp = gen_reg;
                            ram_we = 1'b1;
                        end
                    end
                    default:
                    begin
                        ram_we = 1'b0;
                    end
                endcase
                for (int i = 0; i < W; i++)
                begin
                    ram_wdata[i*SW +: SW] = new_slots[i];
                end
            end
            ttt_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ttt_pkg::ST_IDLE;
                    // A clear command reports once the sweep is over; the reset sweep does not.
                    done_next  = cmd_clear_reg;
                end
            end
            default:
            begin
                state_next = ttt_pkg::ST_IDLE;
            end
        endcase
    end

    // The reset sweep must not report; track it by a flag on the command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_clear_reg <= 1'b0;
        end
        else if (start && !busy)
        begin
            cmd_clear_reg <= (operation == ttt_pkg::OP_CLEAR);
        end
    end

    logic done_gated;
    assign done_gated = done_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> done)
        else $error("hit without done");
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !cmd_clear_reg) |-> !busy || $past(start))
        else $error("done while still working");
    assert property (@(posedge clk) disable iff (!rst_n)
        done_gated |=> !done_gated)
        else $error("result shown for more than one cycle");

endmodule
